// ----- rtl/wsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Wildcard star matcher package
// Shared command codes, cell control type and the star character constant.
// ----------------------------------------------------------------------------
`default_nettype none

package wsm_pkg;

  localparam logic [7:0] STAR_CHAR = 8'h2A;

  typedef enum logic [1:0] {
    CMD_PAT_CHAR  = 2'd0,
    CMD_PAT_END   = 2'd1,
    CMD_NAME_CHAR = 2'd2,
    CMD_NAME_END  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_HOLD  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_ARM   = 2'd2,
    MODE_STEP  = 2'd3
  } cell_mode_e;

  // Broadcast to every cell of the chain in each cycle.
  typedef struct packed {
    cell_mode_e mode;
    logic [7:0] ch;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/wsm_cell.sv -----
// ----------------------------------------------------------------------------
// Wildcard star matcher cell
// One pattern position: the stored pattern character and its NFA active bit.
// ----------------------------------------------------------------------------
`default_nettype none

module wsm_cell #(
  parameter int INDEX = 0,
  parameter int LW    = 7
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wsm_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [LW-1:0]       clen_i,
  input  wire logic                wr_en_i,
  input  wire logic                seed_i,
  input  wire logic                step_i,
  input  wire logic                close_i,
  output logic                     step_o,
  output logic                     close_o,
  output logic                     at_end_o
);

  import wsm_pkg::*;

  localparam logic [LW-1:0] Idx = LW'(INDEX);

  logic [7:0] chr_q;
  logic       active_q, active_d;
  logic       en, is_star, is_match, hold, base;

  assign en       = (Idx < clen_i);
  assign is_star  = (chr_q == STAR_CHAR);
  assign is_match = (chr_q == ctrl_i.ch);
  assign hold     = en & is_star & active_q;

  // Runs of stars are collapsed on load, so a closure never passes a star on
  // to another star and the neighbor links stay one cell deep.
  assign base     = (ctrl_i.mode == MODE_ARM) ? seed_i : (step_i | hold);
  assign step_o   = en & ~is_star & active_q & is_match;
  assign close_o  = en & is_star & base;
  assign at_end_o = active_q & (Idx == clen_i);

  always_comb begin
    unique case (ctrl_i.mode)
      MODE_HOLD:  active_d = active_q;
      MODE_CLEAR: active_d = 1'b0;
      MODE_ARM:   active_d = base | close_i;
      MODE_STEP:  active_d = base | close_i;
      default:    active_d = active_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      chr_q <= ctrl_i.ch;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wildcard_star_matcher.sv -----
// ----------------------------------------------------------------------------
// Wildcard star matcher
// Glob matcher with '*' as the only special character, built as a chain of
// NFA cells, one per pattern position plus the accepting position.
// ----------------------------------------------------------------------------
// Throughput: one input transfer per cycle unless stalled; all cells step together.
// Latency: an end-of-name transfer shows its result on the master side in the
// next cycle, held in an output register; input stalls only while that result
// waits on a receiver that is not ready.
// Reset: clears the active bits, lengths, flags and the output valid; the
// stored pattern characters are not cleared and are read only once written.
`default_nettype none

module wildcard_star_matcher #(
  parameter int MAX_PAT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [1:0] cmd, [9:2] ch, [15:10] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata    // [0] matched, [1] overflow, [7:2] zero
);

  import wsm_pkg::*;

  localparam int LW = $clog2(MAX_PAT + 1);
  localparam logic [LW-1:0] MaxLen = LW'(MAX_PAT);

  logic [LW-1:0] raw_q, raw_d, clen_q, clen_d, eff_raw, eff_clen;
  logic          closed_q, closed_d, ovf_q, ovf_d, last_star_q, last_star_d;
  logic          eff_last_star;
  logic          out_valid_q, out_valid_d, out_match_q, out_ovf_q;
  logic          in_fire, wr_go, ch_star, hit;
  logic [1:0]    cmd;
  logic [7:0]    ch;
  cell_ctrl_t    ctrl;

  logic [MAX_PAT:0] step_w, close_w, at_end_w, wr_en_w;

  assign cmd     = s_axis_tdata[1:0];
  assign ch      = s_axis_tdata[9:2];
  assign ch_star = (ch == STAR_CHAR);

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  // A pattern character after the close starts a fresh pattern.
  assign eff_raw       = closed_q ? '0 : raw_q;
  assign eff_clen      = closed_q ? '0 : clen_q;
  assign eff_last_star = closed_q ? 1'b0 : last_star_q;

  // Consecutive stars match the same as one, so only the first is stored.
  assign wr_go = in_fire && (cmd == CMD_PAT_CHAR) && (eff_raw < MaxLen) &&
                 !(ch_star && eff_last_star);

  assign hit = closed_q & ~ovf_q & (|at_end_w);

  always_comb begin
    raw_d       = raw_q;
    clen_d      = clen_q;
    closed_d    = closed_q;
    ovf_d       = ovf_q;
    last_star_d = last_star_q;
    ctrl.mode   = MODE_HOLD;
    ctrl.ch     = ch;
    if (in_fire) begin
      unique case (cmd)
        CMD_PAT_CHAR: begin
          closed_d    = 1'b0;
          raw_d       = eff_raw;
          clen_d      = eff_clen;
          last_star_d = eff_last_star;
          if (closed_q) begin
            ovf_d     = 1'b0;
            ctrl.mode = MODE_CLEAR;
          end
          if (eff_raw < MaxLen) begin
            raw_d = eff_raw + LW'(1);
            if (wr_go) begin
              clen_d      = eff_clen + LW'(1);
              last_star_d = ch_star;
            end
          end else begin
            ovf_d = 1'b1;
          end
        end
        CMD_PAT_END: begin
          closed_d  = 1'b1;
          ctrl.mode = MODE_ARM;
        end
        CMD_NAME_CHAR: begin
          if (closed_q) begin
            ctrl.mode = MODE_STEP;
          end
        end
        CMD_NAME_END: begin
          if (closed_q) begin
            ctrl.mode = MODE_ARM;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_d = (in_fire && (cmd == CMD_NAME_END)) ? 1'b1 :
                       (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q       <= '0;
      clen_q      <= '0;
      closed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      last_star_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      raw_q       <= raw_d;
      clen_q      <= clen_d;
      closed_q    <= closed_d;
      ovf_q       <= ovf_d;
      last_star_q <= last_star_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (cmd == CMD_NAME_END)) begin
      out_match_q <= hit;
      out_ovf_q   <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_ovf_q, out_match_q};

  for (genvar p = 0; p <= MAX_PAT; p++) begin : g_cell
    logic seed, step_in, close_in;

    assign wr_en_w[p] = wr_go && (eff_clen == LW'(p));

    if (p == 0) begin : g_head
      assign seed     = 1'b1;
      assign step_in  = 1'b0;
      assign close_in = 1'b0;
    end else begin : g_body
      assign seed     = 1'b0;
      assign step_in  = step_w[p-1];
      assign close_in = close_w[p-1];
    end

    wsm_cell #(
      .INDEX (p),
      .LW    (LW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .clen_i   (clen_q),
      .wr_en_i  (wr_en_w[p]),
      .seed_i   (seed),
      .step_i   (step_in),
      .close_i  (close_in),
      .step_o   (step_w[p]),
      .close_o  (close_w[p]),
      .at_end_o (at_end_w[p])
    );
  end

endmodule

`default_nettype wire

// ----- rtl/wsm_checker.sv -----
// ----------------------------------------------------------------------------
// Wildcard star matcher checker
// Port-level assertions on the matcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module wsm_assertions (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [15:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata
);

  import wsm_pkg::*;

  // A stalled result keeps its valid and its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An end-of-name transfer always yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == CMD_NAME_END)
    |=> m_axis_tvalid)
    else $error("end of name gave no result");

  // Input is only held off while a result is waiting.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with the output register empty");

  // An overflowed pattern never reports a match.
  a_ovf_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
    else $error("match reported for an overflowed pattern");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'd0))
    else $error("result padding bits not zero");

endmodule

bind wildcard_star_matcher wsm_assertions u_wsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
